FILE: sv/i2cseq_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
package i2cseq_pkg;

   localparam int TX_DEPTH = 256;
   localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int LP_W     = 9;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_STATUS = 2'd2;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_STOP    = 3'd2;
   localparam logic [2:0] CMD_NEXT    = 3'd3;
   localparam logic [2:0] CMD_RACK    = 3'd4;
   localparam logic [2:0] CMD_RNACK   = 3'd5;
   localparam logic [2:0] CMD_RELEASE = 3'd6;

   localparam logic [1:0] OUT_OK   = 2'd0;
   localparam logic [1:0] OUT_NACK = 2'd1;
   localparam logic [1:0] OUT_ARB  = 2'd2;
   localparam logic [1:0] OUT_BUS  = 2'd3;

   // bus status codes, low three bits masked off
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RSTART     = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
   localparam logic [7:0] ST_DATW_ACK   = 8'h28;
   localparam logic [7:0] ST_DATW_NACK  = 8'h30;
   localparam logic [7:0] ST_ARB_LOST   = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
   localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
   localparam logic [7:0] ST_DATR_ACK   = 8'h50;
   localparam logic [7:0] ST_DATR_NACK  = 8'h58;

   localparam logic [1:0] REG_TARGET_ADDRESS = 2'd0;
   localparam logic [1:0] REG_WRITE_FIRST    = 2'd1;
   localparam logic [1:0] REG_WRITE_COUNT    = 2'd2;
   localparam logic [1:0] REG_READ_COUNT     = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] tx_byte;
      logic [7:0] status_code;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] send_byte;
      logic       send_valid;
      logic [7:0] rx_data;
      logic       rx_valid;
      logic       done_res;
      logic       error;
      logic [1:0] result_code;
      logic       busy_res;
      logic       accepted;
   } rsp_type;

   typedef struct packed {
      logic [6:0] target_address;
      logic       write_first;
      logic [7:0] write_count;
      logic [7:0] read_count;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [TX_AW-1:0] waddr;
      logic [7:0]       wdata;
   } buf_wr_type;

endpackage

FILE: sv/i2cseq_csr.sv
// Configuration register file on the APB-style port.
module i2cseq_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output i2cseq_pkg::cfg_type cfg
);

   logic [6:0] target_address_ff;
   logic       write_first_ff;
   logic [7:0] write_count_ff;
   logic [7:0] read_count_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff <= 7'd0;
         write_first_ff    <= 1'b1;
         write_count_ff    <= 8'd0;
         read_count_ff     <= 8'd0;
      end else if (wr_en) begin
         case (reg_idx)
            i2cseq_pkg::REG_TARGET_ADDRESS: target_address_ff <= csr_pwdata[6:0];
            i2cseq_pkg::REG_WRITE_FIRST:    write_first_ff    <= csr_pwdata[0];
            i2cseq_pkg::REG_WRITE_COUNT:    write_count_ff    <= csr_pwdata[7:0];
            i2cseq_pkg::REG_READ_COUNT:     read_count_ff     <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         i2cseq_pkg::REG_TARGET_ADDRESS: csr_prdata = {25'd0, target_address_ff};
         i2cseq_pkg::REG_WRITE_FIRST:    csr_prdata = {31'd0, write_first_ff};
         i2cseq_pkg::REG_WRITE_COUNT:    csr_prdata = {24'd0, write_count_ff};
         i2cseq_pkg::REG_READ_COUNT:     csr_prdata = {24'd0, read_count_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign cfg.target_address = target_address_ff;
   assign cfg.write_first    = write_first_ff;
   assign cfg.write_count    = write_count_ff;
   assign cfg.read_count     = read_count_ff;

endmodule

FILE: sv/i2cseq_txbuf.sv
// Transmit buffer memory: one write port, one registered read port.
module i2cseq_txbuf (
   input  logic                               clock,
   input  i2cseq_pkg::buf_wr_type             wr,
   input  logic                               re,
   input  logic [i2cseq_pkg::TX_AW-1:0]       raddr,
   output logic [7:0]                         rdata
);

   logic [7:0] mem [i2cseq_pkg::TX_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.waddr] <= wr.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/i2cseq_ctrl.sv
// Sequencer state and per-word step logic.
module i2cseq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  i2cseq_pkg::req_type          item,
   input  logic [7:0]                   buf_rdata,
   input  i2cseq_pkg::cfg_type          cfg,
   output i2cseq_pkg::rsp_type          rsp,
   output i2cseq_pkg::buf_wr_type       buf_wr,
   output logic [i2cseq_pkg::TX_AW-1:0] next_raddr
);

   typedef enum logic [1:0] {PH_IDLE, PH_WRITE, PH_READ} phase_type;

   phase_type                   phase_ff, phase_in;
   logic [7:0]                  send_index_ff, send_index_in;
   logic [7:0]                  receive_index_ff, receive_index_in;
   logic [i2cseq_pkg::LP_W-1:0] load_pointer_ff, load_pointer_in;
   logic [1:0]                  outcome_ff, outcome_in;
   logic [7:0]                  st;
   logic                        si_in_range;
   logic [8:0]                  ri_plus;
   logic                        we_raw;

   assign st          = {item.status_code[7:3], 3'b000};
   assign si_in_range = {1'b0, send_index_ff} < 9'(i2cseq_pkg::TX_DEPTH);
   assign ri_plus     = {1'b0, receive_index_ff + 8'd1} + 9'd1;

   always_comb begin
      rsp              = '0;
      phase_in         = phase_ff;
      send_index_in    = send_index_ff;
      receive_index_in = receive_index_ff;
      load_pointer_in  = load_pointer_ff;
      outcome_in       = outcome_ff;
      we_raw           = 1'b0;
      case (item.op)
         i2cseq_pkg::OP_LOAD: begin
            if (phase_ff == PH_IDLE &&
                load_pointer_ff < i2cseq_pkg::LP_W'(i2cseq_pkg::TX_DEPTH)) begin
               we_raw          = 1'b1;
               load_pointer_in = load_pointer_ff + 1'b1;
               rsp.accepted    = 1'b1;
            end
         end
         i2cseq_pkg::OP_START: begin
            if (phase_ff == PH_IDLE && !(!cfg.write_first && cfg.read_count == 8'd0)) begin
               phase_in         = cfg.write_first ? PH_WRITE : PH_READ;
               send_index_in    = 8'd0;
               receive_index_in = 8'd0;
               load_pointer_in  = '0;
               rsp.bus_command  = i2cseq_pkg::CMD_START;
               rsp.accepted     = 1'b1;
            end
         end
         i2cseq_pkg::OP_STATUS: begin
            if (phase_ff != PH_IDLE) begin
               case (st)
                  i2cseq_pkg::ST_START, i2cseq_pkg::ST_RSTART: begin
                     rsp.send_byte   = {cfg.target_address, phase_ff == PH_READ};
                     rsp.send_valid  = 1'b1;
                     rsp.bus_command = i2cseq_pkg::CMD_NEXT;
                  end
                  i2cseq_pkg::ST_SLAW_ACK, i2cseq_pkg::ST_DATW_ACK: begin
                     if (phase_ff == PH_WRITE && send_index_ff < cfg.write_count) begin
                        rsp.send_byte   = si_in_range ? buf_rdata : 8'd0;
                        rsp.send_valid  = 1'b1;
                        send_index_in   = send_index_ff + 8'd1;
                        rsp.bus_command = i2cseq_pkg::CMD_NEXT;
                     end else if (cfg.read_count != 8'd0) begin
                        phase_in        = PH_READ;
                        rsp.bus_command = i2cseq_pkg::CMD_START;
                     end else begin
                        rsp.bus_command = i2cseq_pkg::CMD_STOP;
                        outcome_in      = i2cseq_pkg::OUT_OK;
                        rsp.done_res    = 1'b1;
                        phase_in        = PH_IDLE;
                     end
                  end
                  i2cseq_pkg::ST_SLAW_NACK, i2cseq_pkg::ST_DATW_NACK,
                  i2cseq_pkg::ST_SLAR_NACK: begin
                     rsp.bus_command = i2cseq_pkg::CMD_STOP;
                     outcome_in      = i2cseq_pkg::OUT_NACK;
                     rsp.error       = 1'b1;
                     phase_in        = PH_IDLE;
                  end
                  i2cseq_pkg::ST_ARB_LOST: begin
                     // bus is let go without a stop condition
                     rsp.bus_command = i2cseq_pkg::CMD_RELEASE;
                     outcome_in      = i2cseq_pkg::OUT_ARB;
                     rsp.error       = 1'b1;
                     phase_in        = PH_IDLE;
                  end
                  i2cseq_pkg::ST_SLAR_ACK: begin
                     rsp.bus_command = (cfg.read_count > 8'd1) ? i2cseq_pkg::CMD_RACK
                                                               : i2cseq_pkg::CMD_RNACK;
                  end
                  i2cseq_pkg::ST_DATR_ACK: begin
                     rsp.rx_data      = item.rx_byte;
                     rsp.rx_valid     = 1'b1;
                     receive_index_in = receive_index_ff + 8'd1;
                     // index after increment, plus one more byte still to come
                     rsp.bus_command  = (ri_plus < {1'b0, cfg.read_count}) ?
                                        i2cseq_pkg::CMD_RACK : i2cseq_pkg::CMD_RNACK;
                  end
                  i2cseq_pkg::ST_DATR_NACK: begin
                     rsp.rx_data      = item.rx_byte;
                     rsp.rx_valid     = 1'b1;
                     receive_index_in = receive_index_ff + 8'd1;
                     rsp.bus_command  = i2cseq_pkg::CMD_STOP;
                     outcome_in       = i2cseq_pkg::OUT_OK;
                     rsp.done_res     = 1'b1;
                     phase_in         = PH_IDLE;
                  end
                  default: begin
                     rsp.bus_command = i2cseq_pkg::CMD_STOP;
                     outcome_in      = i2cseq_pkg::OUT_BUS;
                     rsp.error       = 1'b1;
                     phase_in        = PH_IDLE;
                  end
               endcase
            end
         end
         default: ;
      endcase
      rsp.result_code = outcome_in;
      rsp.busy_res    = phase_in != PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         send_index_ff    <= 8'd0;
         receive_index_ff <= 8'd0;
         load_pointer_ff  <= '0;
         outcome_ff       <= i2cseq_pkg::OUT_OK;
      end else if (advance) begin
         phase_ff         <= phase_in;
         send_index_ff    <= send_index_in;
         receive_index_ff <= receive_index_in;
         load_pointer_ff  <= load_pointer_in;
         outcome_ff       <= outcome_in;
      end
   end

   assign buf_wr.we    = we_raw && advance;
   assign buf_wr.waddr = load_pointer_ff[i2cseq_pkg::TX_AW-1:0];
   assign buf_wr.wdata = item.tx_byte;

   // the following word reads the buffer at the index this word leaves behind
   assign next_raddr = advance ? send_index_in[i2cseq_pkg::TX_AW-1:0]
                               : send_index_ff[i2cseq_pkg::TX_AW-1:0];

endmodule

FILE: sv/i2cseq_ctrl_wrap_unused.sv
// Stage register between input port and step logic, holding the accepted word.
module i2cseq_ctrl_wrap_unused (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                advance,
   input  i2cseq_pkg::req_type req_in,
   output logic                stage_valid,
   output i2cseq_pkg::req_type stage_item
);

   logic                stage_valid_ff, stage_valid_in;
   i2cseq_pkg::req_type stage_item_ff;

   assign stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= req_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_item  = stage_item_ff;

endmodule

FILE: sv/i2cseq_outreg.sv
// Output register on the result channel.
module i2cseq_outreg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  i2cseq_pkg::rsp_type rsp_in,
   input  logic                rsp_stall,
   output logic                out_free,
   output logic                rsp_valid,
   output i2cseq_pkg::rsp_type rsp_payload
);

   logic                rsp_valid_ff, rsp_valid_in;
   i2cseq_pkg::rsp_type rsp_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: sv/i2cseq_core_top_unused.sv
// Result field checks used by the top level.
module i2cseq_core_top_unused (
   input  i2cseq_pkg::rsp_type rsp,
   output logic                consistent
);

   // a finished word never carries both outcomes, and an error never reads as ok
   assign consistent = !(rsp.done_res && rsp.error) &&
                       !(rsp.error && rsp.result_code == i2cseq_pkg::OUT_OK);

endmodule

FILE: sv/i2c_master_transaction_sequencer_core.sv
// I2C master transaction sequencer: top level.
//
// Takes one word per clock while the result side does not stall, and returns
// one result word per input word, through the stage register and then the
// output register. Each word's transmit buffer read is issued as it is
// accepted, at the send index that the word ahead of it leaves, and its
// registered data is used while the word sits in the stage register, where the
// state is updated and the result is placed in the output register. The
// transmit buffer has no reset and no clearing pass; only entries loaded since
// the last start are meant to be sent. The user must write registers only
// while no word is in flight; the block itself does not enforce this.
module i2c_master_transaction_sequencer_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2cseq_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cseq_pkg::rsp_type rsp_payload,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   i2cseq_pkg::cfg_type          cfg;
   i2cseq_pkg::req_type          stage_item;
   i2cseq_pkg::rsp_type          step_rsp;
   i2cseq_pkg::buf_wr_type       buf_wr;
   logic [i2cseq_pkg::TX_AW-1:0] next_raddr;
   logic [7:0]                   buf_rdata;
   logic                         stage_valid;
   logic                         out_free;
   logic                         advance;
   logic                         accept;
   logic                         rsp_ok;

   assign advance   = stage_valid && out_free;
   assign req_stall = stage_valid && !out_free;
   assign accept    = req_valid && !req_stall;

   i2cseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cseq_ctrl_wrap_unused u_stage (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .req_in      (req_payload),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   i2cseq_txbuf u_txbuf (
      .clock (clock),
      .wr    (buf_wr),
      .re    (accept),
      .raddr (next_raddr),
      .rdata (buf_rdata)
   );

   i2cseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (stage_item),
      .buf_rdata  (buf_rdata),
      .cfg        (cfg),
      .rsp        (step_rsp),
      .buf_wr     (buf_wr),
      .next_raddr (next_raddr)
   );

   i2cseq_outreg u_outreg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .rsp_in      (step_rsp),
      .rsp_stall   (rsp_stall),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   i2cseq_core_top_unused u_check (
      .rsp        (rsp_payload),
      .consistent (rsp_ok)
   );

   a_rsp_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ok)
      else $error("result word with conflicting outcome");

   a_send_is_next : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.send_valid) |->
      (rsp_payload.bus_command == i2cseq_pkg::CMD_NEXT && rsp_payload.busy_res))
      else $error("byte to send without a next command");

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.accepted &&
       rsp_payload.bus_command == i2cseq_pkg::CMD_START) |-> rsp_payload.busy_res)
      else $error("accepted start left the sequencer idle");

   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      buf_wr.we |=> (rsp_valid && rsp_payload.accepted && !rsp_payload.busy_res))
      else $error("buffer written outside an accepted load");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the I2C master transaction sequencer core: random traffic, register setup, result checks.
module testbench;
   import i2cseq_pkg::*;

   localparam int     ITEM_TARGET   = 1750;
   localparam int     DRAIN_CYCLES  = 4;
   localparam int     MAX_ERR_LINES = 40;
   localparam longint TIMEOUT_NS    = 4_000_000;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WRITE = 2'd1,
      PH_READ  = 2'd2
   } phase_t;

   typedef struct packed {
      phase_t     phase;
      logic [7:0] send_index;
      logic [7:0] recv_index;
      logic [8:0] load_ptr;
      logic [1:0] outcome;
   } seq_state_t;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   i2c_master_transaction_sequencer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register image, shared by the stimulus planner and the checker
   cfg_type    cfg;

   // checker side: sequencer state at the point of acceptance
   seq_state_t chk_st;
   logic [7:0] tx_store [TX_DEPTH];
   rsp_type    expected_q [$];

   // planner side: runs ahead of the block to shape well-formed transfers
   seq_state_t plan_st;
   logic       plan_written [TX_DEPTH];
   logic [2:0] plan_last_cmd;
   logic [7:0] plan_last_st;
   req_type    pending_q [$];

   int fail_count      = 0;
   int planned         = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int done_seen       = 0;
   int errors_seen     = 0;
   int rx_seen         = 0;
   int settings_used   = 0;

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= MAX_ERR_LINES)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic void close_transfer(inout seq_state_t s, inout rsp_type o,
                                          input logic [1:0] code);
      o.bus_command = CMD_STOP;
      s.outcome     = code;
      if (code == OUT_OK)
         o.done_res = 1'b1;
      else
         o.error = 1'b1;
      s.phase = PH_IDLE;
   endfunction

   // next state and result word for one input word
   function automatic rsp_type sequencer_step(inout seq_state_t s, input cfg_type c,
                                              input req_type r, input logic [7:0] tx_entry);
      rsp_type    o;
      logic [7:0] st;
      o  = '0;
      st = r.status_code & 8'hF8;
      case (r.op)
         OP_LOAD: begin
            if (s.phase == PH_IDLE && s.load_ptr < TX_DEPTH) begin
               s.load_ptr = s.load_ptr + 9'd1;
               o.accepted = 1'b1;
            end
         end
         OP_START: begin
            if (s.phase == PH_IDLE && !(c.write_first == 1'b0 && c.read_count == 8'd0)) begin
               s.phase       = c.write_first ? PH_WRITE : PH_READ;
               s.send_index  = '0;
               s.recv_index  = '0;
               s.load_ptr    = '0;
               o.bus_command = CMD_START;
               o.accepted    = 1'b1;
            end
         end
         OP_STATUS: begin
            if (s.phase != PH_IDLE) begin
               case (st)
                  ST_START, ST_RSTART: begin
                     o.send_byte   = {c.target_address, s.phase == PH_READ};
                     o.send_valid  = 1'b1;
                     o.bus_command = CMD_NEXT;
                  end
                  ST_SLAW_ACK, ST_DATW_ACK: begin
                     if (s.phase == PH_WRITE && s.send_index < c.write_count) begin
                        o.send_byte   = tx_entry;
                        o.send_valid  = 1'b1;
                        s.send_index  = s.send_index + 8'd1;
                        o.bus_command = CMD_NEXT;
                     end else if (c.read_count != 8'd0) begin
                        // repeated start into the read phase
                        s.phase       = PH_READ;
                        o.bus_command = CMD_START;
                     end else begin
                        close_transfer(s, o, OUT_OK);
                     end
                  end
                  ST_SLAW_NACK, ST_DATW_NACK, ST_SLAR_NACK: close_transfer(s, o, OUT_NACK);
                  ST_ARB_LOST: begin
                     // bus is released, no stop
                     o.bus_command = CMD_RELEASE;
                     s.outcome     = OUT_ARB;
                     o.error       = 1'b1;
                     s.phase       = PH_IDLE;
                  end
                  ST_SLAR_ACK: o.bus_command = (c.read_count > 8'd1) ? CMD_RACK : CMD_RNACK;
                  ST_DATR_ACK: begin
                     o.rx_data     = r.rx_byte;
                     o.rx_valid    = 1'b1;
                     s.recv_index  = s.recv_index + 8'd1;
                     o.bus_command = (int'(s.recv_index) + 1 < int'(c.read_count)) ?
                                     CMD_RACK : CMD_RNACK;
                  end
                  ST_DATR_NACK: begin
                     o.rx_data    = r.rx_byte;
                     o.rx_valid   = 1'b1;
                     s.recv_index = s.recv_index + 8'd1;
                     close_transfer(s, o, OUT_OK);
                  end
                  default: close_transfer(s, o, OUT_BUS);
               endcase
            end
         end
         default: ;
      endcase
      o.result_code = s.outcome;
      o.busy_res    = (s.phase != PH_IDLE);
      return o;
   endfunction

   // ---------------------------------------------------------------- register port

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      readback = '0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_TARGET_ADDRESS: begin
            cfg.target_address = value[6:0];
            readback[6:0]      = value[6:0];
         end
         REG_WRITE_FIRST: begin
            cfg.write_first = value[0];
            readback[0]     = value[0];
         end
         REG_WRITE_COUNT: begin
            cfg.write_count = value[7:0];
            readback[7:0]   = value[7:0];
         end
         default: begin
            cfg.read_count = value[7:0];
            readback[7:0]  = value[7:0];
         end
      endcase
      // read the register straight back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== readback)
         flag_error($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                              idx, csr_prdata, readback));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_settings(input logic [6:0] ta, input logic wf,
                                 input logic [7:0] wc, input logic [7:0] rc);
      write_reg(REG_TARGET_ADDRESS, {25'd0, ta});
      write_reg(REG_WRITE_FIRST, {31'd0, wf});
      write_reg(REG_WRITE_COUNT, {24'd0, wc});
      write_reg(REG_READ_COUNT, {24'd0, rc});
      settings_used++;
   endtask

   task automatic random_settings();
      int unsigned pick;
      logic [6:0]  ta;
      logic [7:0]  wc;
      logic [7:0]  rc;
      pick = $urandom_range(0, 5);
      ta   = (pick == 0) ? 7'h00 : (pick == 1) ? 7'h7F : 7'($urandom);
      pick = $urandom_range(0, 9);
      wc   = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 8));
      pick = $urandom_range(0, 9);
      rc   = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd1 :
             8'($urandom_range(0, 8));
      write_settings(ta, 1'($urandom), wc, rc);
   endtask

   // ---------------------------------------------------------------- stimulus planning

   task automatic plan_item(input logic [1:0] op, input logic [7:0] txb,
                            input logic [7:0] st, input logic [7:0] rxb);
      req_type    r;
      rsp_type    o;
      logic [8:0] slot;
      logic       was_busy;
      r.op          = op;
      r.tx_byte     = txb;
      r.status_code = st;
      r.rx_byte     = rxb;
      slot     = plan_st.load_ptr;
      was_busy = (plan_st.phase != PH_IDLE);
      o = sequencer_step(plan_st, cfg, r, 8'h00);
      if (op == OP_LOAD && o.accepted)
         plan_written[slot[7:0]] = 1'b1;
      if ((op == OP_START && o.accepted) || (op == OP_STATUS && was_busy)) begin
         plan_last_cmd = o.bus_command;
         plan_last_st  = st & 8'hF8;
      end
      // status words sent while idle and words with an unused op code are not counted
      if (op == OP_LOAD || op == OP_START || (op == OP_STATUS && was_busy))
         planned++;
      pending_q.push_back(r);
   endtask

   // status a well-behaved bus would report after the last command
   function automatic logic [7:0] next_status();
      logic [7:0] base;
      case (plan_last_cmd)
         CMD_START: base = ($urandom_range(0, 1) != 0) ? ST_START : ST_RSTART;
         CMD_NEXT: begin
            if (plan_last_st == ST_START || plan_last_st == ST_RSTART) begin
               if (plan_st.phase == PH_WRITE)
                  base = ($urandom_range(0, 19) != 0) ? ST_SLAW_ACK : ST_SLAW_NACK;
               else
                  base = ($urandom_range(0, 19) != 0) ? ST_SLAR_ACK : ST_SLAR_NACK;
            end else begin
               base = ($urandom_range(0, 29) != 0) ? ST_DATW_ACK : ST_DATW_NACK;
            end
         end
         CMD_RACK: base = ST_DATR_ACK;
         default:  base = ST_DATR_NACK;
      endcase
      return base;
   endfunction

   task automatic plan_busy_step();
      int unsigned roll;
      logic [7:0]  base;
      roll = $urandom_range(0, 99);
      if (roll < 84)
         base = next_status();
      else if (roll < 88)
         base = ST_ARB_LOST;
      else if (roll < 94)
         base = {5'($urandom_range(0, 11)), 3'b000};
      else if (roll < 97)
         base = 8'($urandom);
      else begin
         plan_item((roll[0] != 0) ? OP_LOAD : OP_START, 8'($urandom), 8'($urandom),
                   8'($urandom));
         return;
      end
      // never send a buffer entry that was never loaded
      if (((base & 8'hF8) == ST_SLAW_ACK || (base & 8'hF8) == ST_DATW_ACK) &&
          plan_st.phase == PH_WRITE && plan_st.send_index < cfg.write_count &&
          !plan_written[plan_st.send_index])
         base = ST_DATW_NACK;
      plan_item(OP_STATUS, 8'($urandom), (base & 8'hF8) | 8'($urandom_range(0, 7)),
                8'($urandom));
   endtask

   task automatic plan_idle_step();
      int unsigned roll;
      int unsigned n_loads;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         plan_item(OP_STATUS, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 6) begin
         plan_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         if (roll < 12)
            n_loads = 0;
         else if (roll < 24)
            n_loads = $urandom_range(0, int'(cfg.write_count) + 3);
         else
            n_loads = cfg.write_count;
         repeat (n_loads) plan_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
         plan_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic plan_phase(input int budget);
      int stop_at;
      stop_at = planned + budget;
      while (planned < stop_at) begin
         if (plan_st.phase == PH_IDLE)
            plan_idle_step();
         else
            plan_busy_step();
      end
   endtask

   task automatic wait_drain();
      // sample on the falling edge so all updates of the rising edge have settled
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   int         burst_left;
   int         gap_left;
   logic [8:0] slot_before;
   rsp_type    want_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            slot_before = chk_st.load_ptr;
            want_next = sequencer_step(chk_st, cfg, req_payload, tx_store[chk_st.send_index]);
            if (req_payload.op == OP_LOAD && want_next.accepted)
               tx_store[slot_before[7:0]] = req_payload.tx_byte;
            expected_q.push_back(want_next);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_payload <= pending_q.pop_front();
               req_valid   <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                               $urandom_range(0, 4);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   rsp_type want_rsp;
   int      stall_mode = 0;
   int      stall_left = 0;
   int      stall_tick = 0;

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         flag_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                              results_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               flag_error("result word with nothing expected");
            end else begin
               want_rsp = expected_q.pop_front();
               check_field("bus_command", rsp_payload.bus_command, want_rsp.bus_command);
               check_field("send_byte",   rsp_payload.send_byte,   want_rsp.send_byte);
               check_field("send_valid",  rsp_payload.send_valid,  want_rsp.send_valid);
               check_field("rx_data",     rsp_payload.rx_data,     want_rsp.rx_data);
               check_field("rx_valid",    rsp_payload.rx_valid,    want_rsp.rx_valid);
               check_field("done_res",    rsp_payload.done_res,    want_rsp.done_res);
               check_field("error",       rsp_payload.error,       want_rsp.error);
               check_field("result_code", rsp_payload.result_code, want_rsp.result_code);
               check_field("busy_res",    rsp_payload.busy_res,    want_rsp.busy_res);
               check_field("accepted",    rsp_payload.accepted,    want_rsp.accepted);
               done_seen   += want_rsp.done_res;
               errors_seen += want_rsp.error;
               rx_seen     += want_rsp.rx_valid;
               results_checked++;
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 200);
         end else begin
            stall_left--;
         end
         stall_tick++;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 4) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((stall_tick % 7) < 3);
         endcase
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      chk_st        = '0;
      plan_st       = '0;
      plan_last_cmd = CMD_NONE;
      plan_last_st  = '0;
      cfg.target_address = 7'd0;
      cfg.write_first    = 1'b1;
      cfg.write_count    = 8'd0;
      cfg.read_count     = 8'd0;
      foreach (plan_written[i]) plan_written[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: full write-then-read transfer and each way a transfer can end
      write_settings(7'h7F, 1'b1, 8'd2, 8'd2);
      plan_item(OP_STATUS, 8'h00, ST_START | 8'h07, 8'hFF);  // dropped while idle
      plan_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      plan_item(OP_LOAD, 8'h00, 8'h00, 8'h00);
      plan_item(OP_LOAD, 8'hFF, 8'h00, 8'h00);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);              // refused, busy
      plan_item(OP_LOAD, 8'hA5, 8'h00, 8'h00);               // refused, busy
      plan_item(OP_STATUS, 8'h00, ST_START, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_SLAW_ACK, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_DATW_ACK | 8'h07, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_DATW_ACK, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_RSTART, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_SLAR_ACK, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_DATR_ACK, 8'hFF);
      plan_item(OP_STATUS, 8'h00, ST_DATR_NACK, 8'h00);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_START, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_SLAW_NACK, 8'h00);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_ARB_LOST, 8'h00);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);
      plan_item(OP_STATUS, 8'h00, 8'hF8, 8'h00);             // unknown status
      wait_drain();
      write_settings(7'h00, 1'b0, 8'd0, 8'd0);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);              // read-only with no bytes
      wait_drain();
      write_reg(REG_READ_COUNT, 32'd1);
      plan_item(OP_START, 8'h00, 8'h00, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_START, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_SLAW_ACK, 8'h00);       // write ack in read phase
      plan_item(OP_STATUS, 8'h00, ST_RSTART, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_SLAR_ACK, 8'h00);
      plan_item(OP_STATUS, 8'h00, ST_DATR_NACK, 8'h5A);
      wait_drain();

      // fill the whole buffer once, then overrun it, then run transfers with a write count of 255
      write_settings(7'h55, 1'b1, 8'd255, 8'd3);
      repeat (TX_DEPTH + 2) plan_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      plan_phase(200);
      wait_drain();

      while (planned < ITEM_TARGET) begin
         random_settings();
         plan_phase($urandom_range(60, 180));
         wait_drain();
      end

      $display("Covered %0d words in, %0d results checked over %0d register settings.",
               words_sent, results_checked, settings_used);
      $display("Transfers: %0d completed, %0d ended in error, %0d bytes received.",
               done_seen, errors_seen, rx_seen);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout: %0d results still outstanding", expected_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
